@@ hdl/tece_pkg.sv @@
// Shared types, character codes and helpers for the terminal escape cursor engine.
`default_nettype none

package tece_pkg;

   // Character codes seen by the parser
   localparam logic [7:0] CH_BS      = 8'h08;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_UP      = 8'h41;
   localparam logic [7:0] CH_DOWN    = 8'h42;
   localparam logic [7:0] CH_RIGHT   = 8'h43;
   localparam logic [7:0] CH_HOME    = 8'h48;
   localparam logic [7:0] CH_CLEAR   = 8'h4A;
   localparam logic [7:0] CH_ERASE_K = 8'h4B;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam logic [7:0] CH_ERASE_X = 8'h58;
   localparam logic [7:0] CH_SET     = 8'h68;
   localparam logic [7:0] CH_RESET   = 8'h6C;
   localparam logic [7:0] CH_SGR     = 8'h6D;

   // Numeric limits and mode numbers of the escape sequences
   localparam logic [9:0]  FIRST_LIMIT  = 10'd99;
   localparam logic [10:0] SECOND_LIMIT = 11'd199;
   localparam logic [3:0]  DEC_BASE     = 4'd10;
   localparam logic [6:0]  MODE_INSERT  = 7'd4;
   localparam logic [6:0]  MODE_CURSOR  = 7'd25;
   localparam logic [6:0]  SGR_NORMAL   = 7'd0;
   localparam logic [6:0]  SGR_HIGH     = 7'd1;
   localparam logic [6:0]  SGR_HALF     = 7'd2;
   localparam logic [6:0]  SGR_NORMAL_B = 7'd27;

   // Glyph colour codes
   localparam logic [1:0] COLOR_NORMAL = 2'd0;
   localparam logic [1:0] COLOR_HIGH   = 2'd1;
   localparam logic [1:0] COLOR_HALF   = 2'd2;

   // Configuration register indexes and reset values
   localparam logic CSR_TEXT_COLUMNS = 1'b0;
   localparam logic CSR_TEXT_ROWS    = 1'b1;
   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [6:0] ROWS_RESET    = 7'd30;

   // Command queue depth between parser and executor
   localparam int CMD_FIFO_DEPTH = 2;

   // Tab spacing and its reciprocal for the tab-stop calculation
   localparam int TAB_STEP  = 8;
   localparam int TAB_SHIFT = 16;
   localparam logic [16:0] TAB_MULT = 17'(((1 << TAB_SHIFT) + TAB_STEP - 1) / TAB_STEP);

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_DRAW,
      ACT_ERASE,
      ACT_CLEAR
   } act_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_BS,
      CMD_TAB,
      CMD_LF,
      CMD_CR,
      CMD_DRAW,
      CMD_UP,
      CMD_DOWN,
      CMD_RIGHT,
      CMD_HOME,
      CMD_CLEAR,
      CMD_ERASE_EOL,
      CMD_ERASE_N,
      CMD_INSERT,
      CMD_COLOR,
      CMD_GOTO,
      CMD_CURSOR
   } cmd_op_type;

   // arg_a: glyph, erase count, flag, colour or goto row; arg_b: goto column
   typedef struct packed {
      cmd_op_type op;
      logic [7:0] arg_a;
      logic [7:0] arg_b;
   } cmd_type;

   typedef struct packed {
      act_type    action;
      logic [6:0] glyph_code;
      logic [7:0] target_col;
      logic [6:0] target_row;
      logic [7:0] cell_count;
      logic [1:0] color_select;
      logic       scroll_up;
      logic [7:0] cursor_col_now;
      logic [6:0] cursor_row_now;
      logic       cursor_visible;
      logic       insert_flag;
   } rsp_type;

   // Next multiple of TAB_STEP strictly above col
   function automatic logic [8:0] tab_stop(input logic [7:0] col);
      logic [8:0]  x;
      logic [25:0] prod;
      logic [8:0]  q;
      logic [13:0] stop;
      x    = 9'(col) + 9'(TAB_STEP);
      prod = 26'(x) * 26'(TAB_MULT);
      q    = prod[TAB_SHIFT +: 9];
      stop = 14'(q) * 14'(TAB_STEP);
      return stop[8:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/terminal_escape_cursor_engine.sv @@
// Top level of the terminal escape cursor engine: parser, command queue, executor.
//
//   Channel   Ports                              Direction  Transfer when
//   req       req_valid/req_ready, req_byte_in   in         valid && ready
//   rsp       rsp_valid/rsp_ready, rsp_*         out        valid && ready
//   csr       csr_write_enable, csr_index, data  in         write_enable high
//
// One byte per cycle sustained while rsp_ready stays high; a byte's result passes the queue
// and then the output register. The queue stores the classified command when it is pushed;
// the executor registers the result when it takes the command from the queue.
// Synchronous reset clears parse state, cursor, modes and the queue; no clearing pass.
// A stalled result holds in the output register; the queue takes FIFO_DEPTH more bytes
// before req_ready drops.
`default_nettype none

module terminal_escape_cursor_engine #(
   parameter int FIFO_DEPTH = tece_pkg::CMD_FIFO_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_byte_in,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [1:0] rsp_action,
   output      logic [6:0] rsp_glyph_code,
   output      logic [7:0] rsp_target_col,
   output      logic [6:0] rsp_target_row,
   output      logic [7:0] rsp_cell_count,
   output      logic [1:0] rsp_color_select,
   output      logic       rsp_scroll_up,
   output      logic [7:0] rsp_cursor_col_now,
   output      logic [6:0] rsp_cursor_row_now,
   output      logic       rsp_cursor_visible,
   output      logic       rsp_insert_flag,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_write_data
);

   logic [7:0]        columns_ff, columns_in;
   logic [6:0]        rows_ff, rows_in;
   logic              front_valid;
   logic              front_ready;
   tece_pkg::cmd_type front_cmd;
   logic              back_valid;
   logic              back_ready;
   tece_pkg::cmd_type back_cmd;
   tece_pkg::rsp_type rsp;

   // Decode configuration writes
   always_comb begin
      columns_in = columns_ff;
      rows_in    = rows_ff;
      if (csr_write_enable) begin
         if (csr_index == tece_pkg::CSR_TEXT_COLUMNS) begin
            columns_in = csr_write_data;
         end else if (csr_index == tece_pkg::CSR_TEXT_ROWS) begin
            rows_in = csr_write_data[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= tece_pkg::COLUMNS_RESET;
         rows_ff    <= tece_pkg::ROWS_RESET;
      end else begin
         columns_ff <= columns_in;
         rows_ff    <= rows_in;
      end
   end

   tece_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .byte_in   (req_byte_in),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   tece_cmd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_cmd)
   );

   tece_cursor u_cursor (
      .clock        (clock),
      .reset        (reset),
      .text_columns (columns_ff),
      .text_rows    (rows_ff),
      .cmd_valid    (back_valid),
      .cmd_ready    (back_ready),
      .cmd          (back_cmd),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp          (rsp)
   );

   // Split the result onto its ports
   assign rsp_action         = rsp.action;
   assign rsp_glyph_code     = rsp.glyph_code;
   assign rsp_target_col     = rsp.target_col;
   assign rsp_target_row     = rsp.target_row;
   assign rsp_cell_count     = rsp.cell_count;
   assign rsp_color_select   = rsp.color_select;
   assign rsp_scroll_up      = rsp.scroll_up;
   assign rsp_cursor_col_now = rsp.cursor_col_now;
   assign rsp_cursor_row_now = rsp.cursor_row_now;
   assign rsp_cursor_visible = rsp.cursor_visible;
   assign rsp_insert_flag    = rsp.insert_flag;

   // No result is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An erase always covers at least one cell
   a_erase_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == tece_pkg::ACT_ERASE) |-> (rsp_cell_count != '0))
      else $error("erase with zero cells");

   // Only printable codes are drawn
   a_draw_glyph: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == tece_pkg::ACT_DRAW) |->
         ({1'b0, rsp_glyph_code} >= tece_pkg::CH_SPACE))
      else $error("draw of a non-printable code");

   // Glyph code is zero unless drawing
   a_glyph_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action != tece_pkg::ACT_DRAW) |-> (rsp_glyph_code == '0))
      else $error("glyph code set without draw");

endmodule

`default_nettype wire

@@ hdl/tece_parser.sv @@
// Front end: escape sequence parser that turns each byte into one command.
`default_nettype none

module tece_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire logic [7:0]       byte_in,
   output      logic             cmd_valid,
   input  wire logic             cmd_ready,
   output      tece_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      PH_START,
      PH_ESC,
      PH_BRACKET,
      PH_NUM1,
      PH_QUEST,
      PH_SEMI,
      PH_NUM2,
      PH_NUM3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [6:0]  first_ff, first_in;
   logic [7:0]  second_ff, second_in;
   logic        accept;
   logic        is_digit;
   logic [3:0]  digit;
   logic [9:0]  first_acc;
   logic [10:0] second_acc;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && cmd_ready;

   // Decimal accumulation of the sequence numbers
   assign is_digit   = byte_in inside {[tece_pkg::CH_DIGIT_0 : tece_pkg::CH_DIGIT_9]};
   assign digit      = byte_in[3:0];
   assign first_acc  = 10'(first_ff) * 10'(tece_pkg::DEC_BASE) + 10'(digit);
   assign second_acc = 11'(second_ff) * 11'(tece_pkg::DEC_BASE) + 11'(digit);

   // Classify the byte against the parse phase
   always_comb begin
      cmd.op    = tece_pkg::CMD_NONE;
      cmd.arg_a = '0;
      cmd.arg_b = '0;
      phase_in  = PH_START;
      first_in  = first_ff;
      second_in = second_ff;
      case (phase_ff)
         PH_START: begin
            if (byte_in == tece_pkg::CH_BS) begin
               cmd.op = tece_pkg::CMD_BS;
            end else if (byte_in == tece_pkg::CH_TAB) begin
               cmd.op = tece_pkg::CMD_TAB;
            end else if (byte_in == tece_pkg::CH_LF) begin
               cmd.op = tece_pkg::CMD_LF;
            end else if (byte_in == tece_pkg::CH_CR) begin
               cmd.op = tece_pkg::CMD_CR;
            end else if (byte_in == tece_pkg::CH_ESC) begin
               phase_in = PH_ESC;
            end else if (byte_in inside {[tece_pkg::CH_SPACE : tece_pkg::CH_TILDE]}) begin
               cmd.op    = tece_pkg::CMD_DRAW;
               cmd.arg_a = byte_in;
            end
         end
         PH_ESC: begin
            if (byte_in == tece_pkg::CH_BRACKET) begin
               phase_in = PH_BRACKET;
            end
         end
         PH_BRACKET: begin
            if (byte_in == tece_pkg::CH_QUEST) begin
               phase_in = PH_QUEST;
            end else if (byte_in == tece_pkg::CH_UP) begin
               cmd.op = tece_pkg::CMD_UP;
            end else if (byte_in == tece_pkg::CH_DOWN) begin
               cmd.op = tece_pkg::CMD_DOWN;
            end else if (byte_in == tece_pkg::CH_RIGHT) begin
               cmd.op = tece_pkg::CMD_RIGHT;
            end else if (byte_in == tece_pkg::CH_HOME) begin
               cmd.op = tece_pkg::CMD_HOME;
            end else if (byte_in == tece_pkg::CH_CLEAR) begin
               cmd.op = tece_pkg::CMD_CLEAR;
            end else if (byte_in == tece_pkg::CH_ERASE_K) begin
               cmd.op = tece_pkg::CMD_ERASE_EOL;
            end else if (is_digit) begin
               first_in = 7'(digit);
               phase_in = PH_NUM1;
            end
         end
         PH_NUM1: begin
            if (byte_in == tece_pkg::CH_SEMI) begin
               phase_in = PH_SEMI;
            end else if (byte_in == tece_pkg::CH_ERASE_X) begin
               if (first_ff != '0) begin
                  cmd.op    = tece_pkg::CMD_ERASE_N;
                  cmd.arg_a = 8'(first_ff);
               end
            end else if (byte_in == tece_pkg::CH_SET || byte_in == tece_pkg::CH_RESET) begin
               if (first_ff == tece_pkg::MODE_INSERT) begin
                  cmd.op    = tece_pkg::CMD_INSERT;
                  cmd.arg_a = 8'(byte_in == tece_pkg::CH_SET);
               end
            end else if (byte_in == tece_pkg::CH_SGR) begin
               if (first_ff == tece_pkg::SGR_NORMAL || first_ff == tece_pkg::SGR_NORMAL_B) begin
                  cmd.op    = tece_pkg::CMD_COLOR;
                  cmd.arg_a = 8'(tece_pkg::COLOR_NORMAL);
               end else if (first_ff == tece_pkg::SGR_HIGH) begin
                  cmd.op    = tece_pkg::CMD_COLOR;
                  cmd.arg_a = 8'(tece_pkg::COLOR_HIGH);
               end else if (first_ff == tece_pkg::SGR_HALF) begin
                  cmd.op    = tece_pkg::CMD_COLOR;
                  cmd.arg_a = 8'(tece_pkg::COLOR_HALF);
               end
            end else if (is_digit) begin
               if (first_acc <= tece_pkg::FIRST_LIMIT) begin
                  first_in = first_acc[6:0];
                  phase_in = PH_NUM1;
               end
            end
         end
         PH_SEMI: begin
            if (is_digit) begin
               second_in = 8'(digit);
               phase_in  = PH_NUM2;
            end
         end
         PH_QUEST: begin
            if (is_digit) begin
               first_in = 7'(digit);
               phase_in = PH_NUM3;
            end
         end
         PH_NUM2: begin
            if (byte_in == tece_pkg::CH_HOME) begin
               cmd.op    = tece_pkg::CMD_GOTO;
               cmd.arg_a = 8'(first_ff);
               cmd.arg_b = second_ff;
            end else if (is_digit) begin
               if (second_acc <= tece_pkg::SECOND_LIMIT) begin
                  second_in = second_acc[7:0];
                  phase_in  = PH_NUM2;
               end
            end
         end
         PH_NUM3: begin
            if (byte_in == tece_pkg::CH_SET || byte_in == tece_pkg::CH_RESET) begin
               if (first_ff == tece_pkg::MODE_CURSOR) begin
                  cmd.op    = tece_pkg::CMD_CURSOR;
                  cmd.arg_a = 8'(byte_in == tece_pkg::CH_SET);
               end
            end else if (is_digit) begin
               if (first_acc <= tece_pkg::FIRST_LIMIT) begin
                  first_in = first_acc[6:0];
                  phase_in = PH_NUM3;
               end
            end
         end
         default: begin
            phase_in = PH_START;
         end
      endcase
   end

   // Hold parse state; advance on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         first_ff  <= '0;
         second_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/tece_cmd_fifo.sv @@
// Short command queue between the parser and the cursor executor.
`default_nettype none

module tece_cmd_fifo #(
   parameter int DEPTH = tece_pkg::CMD_FIFO_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output      logic              push_ready,
   input  wire tece_pkg::cmd_type push_data,
   output      logic              pop_valid,
   input  wire logic              pop_ready,
   output      tece_pkg::cmd_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tece_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers with wrap at the queue end
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/tece_cursor.sv @@
// Back end: applies commands to the cursor and mode state and registers the result.
`default_nettype none

module tece_cursor (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        text_columns,
   input  wire logic [6:0]        text_rows,
   input  wire logic              cmd_valid,
   output      logic              cmd_ready,
   input  wire tece_pkg::cmd_type cmd,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      tece_pkg::rsp_type rsp
);

   logic [7:0] col_ff, col_in;
   logic [6:0] row_ff, row_in;
   logic [1:0] color_ff, color_in;
   logic       show_ff, show_in;
   logic       insert_ff, insert_in;
   logic       rsp_valid_ff;
   tece_pkg::rsp_type rsp_ff, rsp_in;

   logic       take;
   logic [7:0] row_inc;
   logic       down_scroll;
   logic [6:0] last_row;
   logic [8:0] col_inc;
   logic       right_wrap;
   logic [7:0] last_col;
   logic [8:0] tab_col;
   logic       tab_wrap;
   logic [8:0] erase_raw;
   logic [8:0] erase_end;
   logic       do_newline;
   logic       do_down;
   logic       scroll;

   // Accept a command when the output register is free or draining
   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign take      = cmd_valid && cmd_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Cursor movement terms
   assign row_inc     = {1'b0, row_ff} + 8'd1;
   assign down_scroll = row_inc >= {1'b0, text_rows};
   assign last_row    = (text_rows == '0) ? '0 : text_rows - 7'd1;
   assign col_inc     = {1'b0, col_ff} + 9'd1;
   assign right_wrap  = col_inc >= {1'b0, text_columns};
   assign last_col    = (text_columns == '0) ? '0 : text_columns - 8'd1;
   assign tab_col     = tece_pkg::tab_stop(col_ff);
   assign tab_wrap    = tab_col >= {1'b0, text_columns};
   assign erase_raw   = {1'b0, col_ff} + {1'b0, cmd.arg_a};
   assign erase_end   = (erase_raw > {1'b0, text_columns}) ? {1'b0, text_columns} : erase_raw;

   // Execute one command
   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      color_in   = color_ff;
      show_in    = show_ff;
      insert_in  = insert_ff;
      do_newline = 1'b0;
      do_down    = 1'b0;
      scroll     = 1'b0;
      rsp_in.action     = tece_pkg::ACT_NONE;
      rsp_in.glyph_code = '0;
      rsp_in.target_col = '0;
      rsp_in.target_row = '0;
      rsp_in.cell_count = '0;
      case (cmd.op)
         tece_pkg::CMD_BS: begin
            if (col_ff != '0) begin
               col_in = col_ff - 8'd1;
            end else if (row_ff != '0) begin
               col_in = last_col;
               row_in = row_ff - 7'd1;
            end
         end
         tece_pkg::CMD_TAB: begin
            if (tab_wrap) begin
               do_newline = 1'b1;
            end else begin
               col_in = tab_col[7:0];
            end
         end
         tece_pkg::CMD_LF: begin
            do_newline = 1'b1;
         end
         tece_pkg::CMD_CR: begin
            col_in = '0;
         end
         tece_pkg::CMD_DRAW: begin
            rsp_in.action     = tece_pkg::ACT_DRAW;
            rsp_in.glyph_code = cmd.arg_a[6:0];
            rsp_in.target_col = col_ff;
            rsp_in.target_row = row_ff;
            if (right_wrap) begin
               do_newline = 1'b1;
            end else begin
               col_in = col_inc[7:0];
            end
         end
         tece_pkg::CMD_UP: begin
            if (row_ff != '0) begin
               row_in = row_ff - 7'd1;
            end
         end
         tece_pkg::CMD_DOWN: begin
            do_down = 1'b1;
         end
         tece_pkg::CMD_RIGHT: begin
            if (right_wrap) begin
               do_newline = 1'b1;
            end else begin
               col_in = col_inc[7:0];
            end
         end
         tece_pkg::CMD_HOME: begin
            col_in = '0;
            row_in = '0;
         end
         tece_pkg::CMD_CLEAR: begin
            rsp_in.action     = tece_pkg::ACT_CLEAR;
            rsp_in.target_col = col_ff;
            rsp_in.target_row = row_ff;
         end
         tece_pkg::CMD_ERASE_EOL: begin
            if (col_ff < text_columns) begin
               rsp_in.action     = tece_pkg::ACT_ERASE;
               rsp_in.target_col = col_ff;
               rsp_in.target_row = row_ff;
               rsp_in.cell_count = text_columns - col_ff;
            end
         end
         tece_pkg::CMD_ERASE_N: begin
            if ({1'b0, col_ff} < erase_end) begin
               rsp_in.action     = tece_pkg::ACT_ERASE;
               rsp_in.target_col = col_ff;
               rsp_in.target_row = row_ff;
               rsp_in.cell_count = 8'(erase_end - {1'b0, col_ff});
            end
         end
         tece_pkg::CMD_INSERT: begin
            insert_in = cmd.arg_a[0];
         end
         tece_pkg::CMD_COLOR: begin
            color_in = cmd.arg_a[1:0];
         end
         tece_pkg::CMD_CURSOR: begin
            show_in = cmd.arg_a[0];
         end
         tece_pkg::CMD_GOTO: begin
            if (cmd.arg_a != '0 && cmd.arg_a <= {1'b0, text_rows} &&
                cmd.arg_b != '0 && cmd.arg_b <= text_columns) begin
               col_in = cmd.arg_b - 8'd1;
               row_in = 7'(cmd.arg_a - 8'd1);
            end
         end
         default: begin
            col_in = col_ff;
         end
      endcase

      // New line: column to zero, then step down
      if (do_newline) begin
         col_in  = '0;
         do_down = 1'b1;
      end
      if (do_down) begin
         if (down_scroll) begin
            scroll = 1'b1;
            row_in = last_row;
         end else begin
            row_in = row_inc[6:0];
         end
      end

      rsp_in.color_select   = color_in;
      rsp_in.scroll_up      = scroll;
      rsp_in.cursor_col_now = col_in;
      rsp_in.cursor_row_now = row_in;
      rsp_in.cursor_visible = show_in;
      rsp_in.insert_flag    = insert_in;
   end

   // Hold cursor state and the valid flag of the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         color_ff     <= tece_pkg::COLOR_NORMAL;
         show_ff      <= 1'b1;
         insert_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            col_ff       <= col_in;
            row_ff       <= row_in;
            color_ff     <= color_in;
            show_ff      <= show_in;
            insert_ff    <= insert_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
